@@ sv/phc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phc_pkg: shared types and constants of the packet header checker
// Holds the header geometry, status codes, register indexes and word layouts.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int HDR_LEN    = 28;
    localparam int CNT_W      = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int OUTQ_DEPTH = 4;
    localparam int TDATA_W    = 184;

    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [31:0]      WIRE_MAGIC    = 32'h5446_4d50;
    localparam logic [7:0]       WIRE_VERSION  = 8'd1;

    localparam logic [7:0]       KIND_LO_RST   = 8'd1;
    localparam logic [7:0]       KIND_HI_RST   = 8'd8;
    localparam logic [15:0]      PAY_LIM_RST   = 16'd1024;
    localparam logic [CNT_W-1:0] PKT_LIM_RST   = 17'd1052;

    localparam logic [CFG_ADDR_W-1:0] REG_KIND_LO = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KIND_HI = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAY_LIM = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PKT_LIM = 3'd3;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_LONG     = 4'd2,
        ST_MAGIC    = 4'd3,
        ST_VERSION  = 4'd4,
        ST_KIND     = 4'd5,
        ST_FLAGS    = 4'd6,
        ST_LEN_MIS  = 4'd7,
        ST_PAY_BIG  = 4'd8,
        ST_ZERO_ID  = 4'd9
    } status_t;

    localparam logic RT_PAYLOAD = 1'b0;
    localparam logic RT_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0]       kind_lo;
        logic [7:0]       kind_hi;
        logic [15:0]      pay_lim;
        logic [CNT_W-1:0] pkt_lim;
    } cfg_t;

    typedef struct packed {
        logic        result_type;
        logic [7:0]  payload_value;
        status_t     status;
        logic [7:0]  kind;
        logic [31:0] session_hash;
        logic [31:0] sender;
        logic [31:0] receiver;
        logic [31:0] cookie;
        logic [15:0] sequence_res;
        logic        binary_flag;
        logic [15:0] declared_len;
    } res_t;

    typedef struct packed {
        logic vld_a;
        logic vld_b;
    } push_t;

endpackage
`default_nettype wire

@@ sv/packet_header_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_checker: streaming packet header checker
// Captures the 28-byte header in a chain of byte cells, forwards payload
// bytes and emits a status summary on the last byte of each packet.
// ----------------------------------------------------------------------------
// With an empty queue a byte's first word is offered in the cycle after the byte;
// a summary follows any payload word of its byte. Throughput: one byte per cycle
// while s_tready is high; the last byte writes up to two words into a four-word
// output queue, which drains one word per cycle while m_tready is high. Input
// stalls while three or more words wait. Synchronous reset (aresetn low) clears
// the byte count, queue and registers to defaults; header cells are not reset.
// ----------------------------------------------------------------------------
module packet_header_checker #(
    parameter int OUTQ_DEPTH = phc_pkg::OUTQ_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [phc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [phc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // data_byte
    input  wire logic                              s_tlast,  // end_of_packet
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // payload_value, status, kind, session_hash, sender, receiver, cookie,
    // sequence_res, binary_flag, declared_len, zero fill
    output logic [phc_pkg::TDATA_W-1:0]            m_tdata,
    output logic                                   m_tuser   // result_type
);

    localparam int HL = phc_pkg::HDR_LEN;

    phc_pkg::cfg_t                 cfg_reg, cfg_next;
    logic [phc_pkg::CNT_W-1:0]     byte_cnt_reg, byte_cnt_next;
    logic [phc_pkg::CNT_W-1:0]     cnt_inc;
    logic                          s_acc;
    logic                          in_hdr;
    logic                          at_hdr_end;
    logic                          is_payload;
    logic [HL-1:0][7:0]            cell_q;
    logic [HL-1:0][7:0]            hdr_view;
    phc_pkg::res_t                 summary;
    phc_pkg::res_t                 pay_res;
    phc_pkg::res_t                 data_a;
    phc_pkg::res_t                 out_data;
    phc_pkg::push_t                push;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                phc_pkg::REG_KIND_LO: cfg_next.kind_lo = cfg_wdata[7:0];
                phc_pkg::REG_KIND_HI: cfg_next.kind_hi = cfg_wdata[7:0];
                phc_pkg::REG_PAY_LIM: cfg_next.pay_lim = cfg_wdata[15:0];
                phc_pkg::REG_PKT_LIM: cfg_next.pkt_lim = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    assign s_acc      = s_tvalid && s_tready;
    assign in_hdr     = (byte_cnt_reg < phc_pkg::CNT_W'(HL));
    assign at_hdr_end = (byte_cnt_reg == phc_pkg::CNT_W'(HL - 1));
    assign is_payload = !in_hdr;
    assign cnt_inc    = (byte_cnt_reg == phc_pkg::CNT_MAX) ? byte_cnt_reg
                                                           : byte_cnt_reg + 1'b1;

    always_comb begin
        byte_cnt_next = byte_cnt_reg;
        if (s_acc) begin
            byte_cnt_next = s_tlast ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '{kind_lo: phc_pkg::KIND_LO_RST,
                              kind_hi: phc_pkg::KIND_HI_RST,
                              pay_lim: phc_pkg::PAY_LIM_RST,
                              pkt_lim: phc_pkg::PKT_LIM_RST};
            byte_cnt_reg <= '0;
        end else begin
            cfg_reg      <= cfg_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // Byte k of the header settles in cell HL-1-k once the header is complete.
    for (genvar i = 0; i < HL; i++) begin : g_cell
        logic [7:0] d_in;
        if (i == 0) begin : g_head
            assign d_in = s_tdata;
        end else begin : g_link
            assign d_in = cell_q[i-1];
        end
        phc_cell u_cell (
            .aclk     (aclk),
            .shift_en (s_acc && in_hdr),
            .d_in     (d_in),
            .q        (cell_q[i])
        );
    end

    // When the last header byte arrives with end of packet, the view is taken
    // as the chain will be after this shift.
    for (genvar k = 0; k < HL; k++) begin : g_view
        if (k == HL - 1) begin : g_last
            assign hdr_view[k] = at_hdr_end ? s_tdata : cell_q[0];
        end else begin : g_body
            assign hdr_view[k] = at_hdr_end ? cell_q[HL-2-k] : cell_q[HL-1-k];
        end
    end

    phc_check u_check (
        .hdr     (hdr_view),
        .cnt     (cnt_inc),
        .cfg     (cfg_reg),
        .summary (summary)
    );

    always_comb begin
        pay_res               = '0;
        pay_res.result_type   = phc_pkg::RT_PAYLOAD;
        pay_res.payload_value = s_tdata;
        data_a                = is_payload ? pay_res : summary;
        push.vld_a            = s_acc && (is_payload || s_tlast);
        push.vld_b            = s_acc && is_payload && s_tlast;
    end

    phc_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .data_a    (data_a),
        .data_b    (summary),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.result_type;
    assign m_tdata = {3'b000,
                      out_data.declared_len,
                      out_data.binary_flag,
                      out_data.sequence_res,
                      out_data.cookie,
                      out_data.receiver,
                      out_data.sender,
                      out_data.session_hash,
                      out_data.kind,
                      out_data.status,
                      out_data.payload_value};

    a_cnt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (byte_cnt_reg == '0))
        else $error("byte count not cleared after end of packet");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_tlast || is_payload)) |=> m_tvalid)
        else $error("result word missing after accepted byte");

    a_bad_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && m_tdata[11:8] != 4'd0) |-> (m_tdata[183:12] == '0))
        else $error("header fields not zero in failed summary");

    a_hdr_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[183:8] == '0))
        else $error("payload word carries summary fields");

endmodule
`default_nettype wire

@@ sv/phc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phc_cell: one byte cell of the header chain
// Takes its neighbor's byte when the chain shifts and holds it otherwise.
// ----------------------------------------------------------------------------
module phc_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_in,
    output logic      [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = shift_en ? d_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule
`default_nettype wire

@@ sv/phc_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phc_check: end-of-packet summary evaluation
// Runs the ordered header checks and builds the summary word.
// ----------------------------------------------------------------------------
module phc_check (
    input  wire logic [phc_pkg::HDR_LEN-1:0][7:0] hdr,
    input  wire logic [phc_pkg::CNT_W-1:0]        cnt,
    input  wire phc_pkg::cfg_t                    cfg,
    output phc_pkg::res_t                         summary
);

    logic [31:0]               magic;
    logic [7:0]                kind;
    logic [7:0]                flag_byte;
    logic [31:0]               session_hash;
    logic [31:0]               sender;
    logic [31:0]               receiver;
    logic [31:0]               cookie;
    logic [15:0]               seq_no;
    logic [15:0]               plen;
    logic [phc_pkg::CNT_W-1:0] body_len;
    phc_pkg::status_t          status;

    assign magic        = {hdr[0], hdr[1], hdr[2], hdr[3]};
    assign kind         = hdr[5];
    assign flag_byte    = hdr[6];
    assign session_hash = {hdr[8], hdr[9], hdr[10], hdr[11]};
    assign sender       = {hdr[12], hdr[13], hdr[14], hdr[15]};
    assign receiver     = {hdr[16], hdr[17], hdr[18], hdr[19]};
    assign seq_no       = {hdr[20], hdr[21]};
    assign plen         = {hdr[22], hdr[23]};
    assign cookie       = {hdr[24], hdr[25], hdr[26], hdr[27]};
    assign body_len     = cnt - phc_pkg::CNT_W'(phc_pkg::HDR_LEN);

    always_comb begin
        if (cnt < phc_pkg::CNT_W'(phc_pkg::HDR_LEN)) begin
            status = phc_pkg::ST_SHORT;
        end else if (cnt > cfg.pkt_lim) begin
            status = phc_pkg::ST_LONG;
        end else if (magic != phc_pkg::WIRE_MAGIC) begin
            status = phc_pkg::ST_MAGIC;
        end else if (hdr[4] != phc_pkg::WIRE_VERSION) begin
            status = phc_pkg::ST_VERSION;
        end else if (kind < cfg.kind_lo || kind > cfg.kind_hi) begin
            status = phc_pkg::ST_KIND;
        end else if (flag_byte[7:1] != 7'd0 || hdr[7] != 8'd0) begin
            status = phc_pkg::ST_FLAGS;
        end else if ({1'b0, plen} != body_len) begin
            status = phc_pkg::ST_LEN_MIS;
        end else if (plen > cfg.pay_lim) begin
            status = phc_pkg::ST_PAY_BIG;
        end else if (session_hash == 32'd0 || sender == 32'd0) begin
            status = phc_pkg::ST_ZERO_ID;
        end else begin
            status = phc_pkg::ST_OK;
        end
    end

    always_comb begin
        summary               = '0;
        summary.result_type   = phc_pkg::RT_SUMMARY;
        summary.status        = status;
        if (status == phc_pkg::ST_OK) begin
            summary.kind           = kind;
            summary.session_hash   = session_hash;
            summary.sender         = sender;
            summary.receiver       = receiver;
            summary.cookie         = cookie;
            summary.sequence_res   = seq_no;
            summary.binary_flag    = flag_byte[0];
            summary.declared_len   = plen;
        end
    end

endmodule
`default_nettype wire

@@ sv/phc_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phc_outq: result word queue
// Takes up to two words per cycle in order and hands one word per cycle out while out_ready is high.
// ----------------------------------------------------------------------------
module phc_outq #(
    parameter int DEPTH = phc_pkg::OUTQ_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire phc_pkg::push_t push,
    input  wire phc_pkg::res_t  data_a,
    input  wire phc_pkg::res_t  data_b,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output phc_pkg::res_t      out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    phc_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] tail_p1, tail_p2;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    always_comb begin
        pop       = (cnt_reg != '0) && out_ready;
        tail_p1   = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        tail_p2   = (tail_p1 == PW'(DEPTH - 1)) ? '0 : tail_p1 + 1'b1;
        head_next = head_reg;
        if (pop) begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        tail_next = tail_reg;
        if (push.vld_a) begin
            tail_next = push.vld_b ? tail_p2 : tail_p1;
        end
        cnt_next = cnt_reg + CW'(push.vld_a) + CW'(push.vld_b) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.vld_a) begin
            mem_reg[tail_reg] <= data_a;
        end
        if (push.vld_b) begin
            mem_reg[tail_p1] <= data_b;
        end
    end

    assign in_ready  = (cnt_reg <= CW'(DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[head_reg];

endmodule
`default_nettype wire

@@ tb/sv/tb_packet_header_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_header_checker: self-checking testbench of the packet header checker
// Frames are built byte by byte, sent with random bursts and gaps, and every
// output word is compared field by field with a behavioral prediction of the
// header capture, payload forwarding and end-of-frame status summary.
// ----------------------------------------------------------------------------
module tb_packet_header_checker;
    import phc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd5;

    localparam int RX_OPEN     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    typedef enum int {
        FLAW_NONE, FLAW_SHORT, FLAW_LONG, FLAW_MAGIC, FLAW_VERSION,
        FLAW_KIND, FLAW_FLAGS, FLAW_LENGTH, FLAW_ZERO_ID
    } flaw_t;

    typedef struct {
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  kind;
        logic [7:0]  flag_byte;
        logic [7:0]  rsv_byte;
        logic [31:0] session_hash;
        logic [31:0] sender;
        logic [31:0] receiver;
        logic [15:0] seq_num;
        logic [15:0] plen;
        logic [31:0] cookie;
    } frame_hdr_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [TDATA_W-1:0]    m_tdata;
    wire                   m_tuser;

    packet_header_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predicted state of the block.
    logic [7:0]       cfg_kind_lo = KIND_LO_RST;
    logic [7:0]       cfg_kind_hi = KIND_HI_RST;
    logic [15:0]      cfg_pay_lim = PAY_LIM_RST;
    logic [CNT_W-1:0] cfg_pkt_lim = PKT_LIM_RST;
    logic [CNT_W-1:0] frame_bytes = '0;
    logic [7:0]       hdr_bytes [HDR_LEN];
    res_t             due_words [$];

    logic [7:0] pkt_q [$];
    int         err_cnt       = 0;
    int         cycles        = 0;
    int         bytes_sent    = 0;
    int         payload_seen  = 0;
    int         summary_seen  = 0;
    logic [9:0] status_seen   = '0;
    int         tx_burst_left = 0;
    int         tx_gap_max    = 3;
    int         rx_hold_req   = 0;
    int         rx_hold_left  = 0;
    int         rx_mode       = RX_OPEN;
    int         rx_mode_left  = 0;
    int         rx_tick       = 0;
    res_t       seen_word;
    res_t       want_word;

    function automatic status_t frame_status(logic [CNT_W-1:0] cnt);
        logic [31:0] magic;
        logic [31:0] shash;
        logic [31:0] sndr;
        logic [15:0] plen;
        magic = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
        shash = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
        sndr  = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
        plen  = {hdr_bytes[22], hdr_bytes[23]};
        if (cnt < HDR_LEN) return ST_SHORT;
        if (cnt > cfg_pkt_lim) return ST_LONG;
        if (magic != WIRE_MAGIC) return ST_MAGIC;
        if (hdr_bytes[4] != WIRE_VERSION) return ST_VERSION;
        if (hdr_bytes[5] < cfg_kind_lo || hdr_bytes[5] > cfg_kind_hi) return ST_KIND;
        if (hdr_bytes[6][7:1] != 7'd0 || hdr_bytes[7] != 8'd0) return ST_FLAGS;
        if (int'(plen) != int'(cnt) - HDR_LEN) return ST_LEN_MIS;
        if (plen > cfg_pay_lim) return ST_PAY_BIG;
        if (shash == 32'd0 || sndr == 32'd0) return ST_ZERO_ID;
        return ST_OK;
    endfunction

    function automatic void absorb_byte(logic [7:0] b, logic last);
        res_t w;
        w = '0;
        if (frame_bytes < HDR_LEN) begin
            hdr_bytes[frame_bytes] = b;
        end else begin
            w.result_type   = RT_PAYLOAD;
            w.payload_value = b;
            due_words.push_back(w);
        end
        if (frame_bytes != CNT_MAX) frame_bytes++;
        if (last) begin
            w = '0;
            w.result_type = RT_SUMMARY;
            w.status      = frame_status(frame_bytes);
            if (w.status == ST_OK) begin
                w.kind         = hdr_bytes[5];
                w.session_hash = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
                w.sender       = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
                w.receiver     = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
                w.cookie       = {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26], hdr_bytes[27]};
                w.sequence_res = {hdr_bytes[20], hdr_bytes[21]};
                w.binary_flag  = hdr_bytes[6][0];
                w.declared_len = {hdr_bytes[22], hdr_bytes[23]};
            end
            due_words.push_back(w);
            frame_bytes = '0;
        end
    endfunction

    function automatic void check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word.result_type    = m_tuser;
            seen_word.payload_value  = m_tdata[7:0];
            seen_word.status         = status_t'(m_tdata[11:8]);
            seen_word.kind           = m_tdata[19:12];
            seen_word.session_hash   = m_tdata[51:20];
            seen_word.sender         = m_tdata[83:52];
            seen_word.receiver       = m_tdata[115:84];
            seen_word.cookie         = m_tdata[147:116];
            seen_word.sequence_res   = m_tdata[163:148];
            seen_word.binary_flag    = m_tdata[164];
            seen_word.declared_len   = m_tdata[180:165];
            if (due_words.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, actual tuser %0b tdata %h",
                             $time, m_tuser, m_tdata);
            end else begin
                want_word = due_words.pop_front();
                check_field("result_type", want_word.result_type, seen_word.result_type);
                check_field("payload_value", want_word.payload_value, seen_word.payload_value);
                check_field("status", want_word.status, seen_word.status);
                check_field("kind", want_word.kind, seen_word.kind);
                check_field("session_hash", want_word.session_hash, seen_word.session_hash);
                check_field("sender", want_word.sender, seen_word.sender);
                check_field("receiver", want_word.receiver, seen_word.receiver);
                check_field("cookie", want_word.cookie, seen_word.cookie);
                check_field("sequence_res", want_word.sequence_res, seen_word.sequence_res);
                check_field("binary_flag", want_word.binary_flag, seen_word.binary_flag);
                check_field("declared_len", want_word.declared_len,
                            seen_word.declared_len);
            end
            if (seen_word.result_type == RT_SUMMARY) begin
                summary_seen++;
                if (seen_word.status <= ST_ZERO_ID) status_seen[seen_word.status] = 1'b1;
            end else begin
                payload_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        rx_tick++;
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(RX_OPEN, RX_PERIODIC);
                rx_mode_left = $urandom_range(20, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
                default:     m_tready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time, due_words.size());
            $display("tb_packet_header_checker NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_burst_left == 0) begin
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            tx_burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        tx_burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
        pkt_q.delete();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (due_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_KIND_LO: cfg_kind_lo = val[7:0];
            REG_KIND_HI: cfg_kind_hi = val[7:0];
            REG_PAY_LIM: cfg_pay_lim = val[15:0];
            REG_PKT_LIM: cfg_pkt_lim = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [15:0] pay, input logic [CNT_W-1:0] pkt);
        write_reg(REG_KIND_LO, CFG_DATA_W'(lo));
        write_reg(REG_KIND_HI, CFG_DATA_W'(hi));
        write_reg(REG_PAY_LIM, CFG_DATA_W'(pay));
        write_reg(REG_PKT_LIM, CFG_DATA_W'(pkt));
    endtask

    function automatic logic [31:0] nonzero_word();
        logic [31:0] v;
        do v = $urandom; while (v == 32'd0);
        return v;
    endfunction

    function automatic logic [7:0] legal_kind();
        if (cfg_kind_lo <= cfg_kind_hi) return 8'($urandom_range(cfg_kind_lo, cfg_kind_hi));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] illegal_kind();
        if (cfg_kind_lo > 8'd0 && cfg_kind_lo <= cfg_kind_hi)
            return 8'($urandom_range(0, cfg_kind_lo - 1));
        if (cfg_kind_hi < 8'd255 && cfg_kind_lo <= cfg_kind_hi)
            return 8'($urandom_range(cfg_kind_hi + 1, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic frame_hdr_t valid_header(int plen);
        frame_hdr_t h;
        h.magic        = WIRE_MAGIC;
        h.version      = WIRE_VERSION;
        h.kind         = legal_kind();
        h.flag_byte    = {7'd0, 1'($urandom_range(0, 1))};
        h.rsv_byte     = 8'd0;
        h.session_hash = nonzero_word();
        h.sender       = nonzero_word();
        h.receiver     = $urandom;
        h.seq_num      = 16'($urandom);
        h.plen         = 16'(plen);
        h.cookie       = $urandom;
        return h;
    endfunction

    function automatic void push_be(logic [31:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) pkt_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_header(frame_hdr_t h);
        push_be(h.magic, 4);
        pkt_q.push_back(h.version);
        pkt_q.push_back(h.kind);
        pkt_q.push_back(h.flag_byte);
        pkt_q.push_back(h.rsv_byte);
        push_be(h.session_hash, 4);
        push_be(h.sender, 4);
        push_be(h.receiver, 4);
        push_be(32'(h.seq_num), 2);
        push_be(32'(h.plen), 2);
        push_be(h.cookie, 4);
    endfunction

    function automatic void push_payload(int n);
        repeat (n) pkt_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_frame(input frame_hdr_t h, input int n);
        push_header(h);
        push_payload(n);
        send_packet();
    endtask

    task automatic test_basic_frames();
        frame_hdr_t h;
        h = valid_header(0);
        h.kind      = cfg_kind_lo;
        h.flag_byte = 8'h01;
        send_frame(h, 0);
        h = valid_header(4);
        h.kind         = cfg_kind_hi;
        h.flag_byte    = 8'h00;
        h.session_hash = '1;
        h.sender       = '1;
        h.receiver     = '1;
        h.cookie       = '1;
        h.seq_num      = '1;
        push_header(h);
        pkt_q.push_back(8'h00);
        pkt_q.push_back(8'hFF);
        pkt_q.push_back(8'hA5);
        pkt_q.push_back(8'h5A);
        send_packet();
        h = valid_header(2);
        h.session_hash = 32'd1;
        h.sender       = 32'd1;
        h.receiver     = '0;
        h.cookie       = '0;
        h.seq_num      = '0;
        send_frame(h, 2);
    endtask

    task automatic test_status_codes();
        frame_hdr_t h;
        push_payload(1);
        send_packet();
        push_header(valid_header(0));
        void'(pkt_q.pop_back());
        send_packet();
        h = valid_header(3);
        h.magic = WIRE_MAGIC ^ 32'h8000_0000;
        send_frame(h, 3);
        h = valid_header(1);
        h.version = 8'd0;
        send_frame(h, 1);
        h.version = 8'd2;
        send_frame(h, 1);
        h = valid_header(0);
        h.kind = cfg_kind_lo - 8'd1;
        send_frame(h, 0);
        h.kind = cfg_kind_hi + 8'd1;
        send_frame(h, 0);
        h = valid_header(2);
        h.flag_byte = 8'h02;
        send_frame(h, 2);
        h.flag_byte = 8'hFF;
        send_frame(h, 2);
        h.flag_byte = 8'h01;
        h.rsv_byte  = 8'h80;
        send_frame(h, 2);
        h = valid_header(3);
        send_frame(h, 4);
        h = valid_header(1);
        h.session_hash = '0;
        send_frame(h, 1);
        h = valid_header(1);
        h.sender = '0;
        send_frame(h, 1);
        wait_idle();
        set_limits(KIND_LO_RST, KIND_HI_RST, 16'd4, PKT_LIM_RST);
        send_frame(valid_header(5), 5);
        send_frame(valid_header(4), 4);
        wait_idle();
        set_limits(KIND_LO_RST, KIND_HI_RST, PAY_LIM_RST, 17'd28);
        send_frame(valid_header(1), 1);
        send_frame(valid_header(0), 0);
        wait_idle();
        set_limits(KIND_LO_RST, KIND_HI_RST, PAY_LIM_RST, PKT_LIM_RST);
    endtask

    task automatic test_register_settings();
        frame_hdr_t h;
        write_reg(REG_NONE, '1);
        h = valid_header(1);
        h.kind = KIND_HI_RST;
        send_frame(h, 1);
        wait_idle();
        set_limits(8'd0, 8'd255, 16'd0, 17'd28);
        h = valid_header(0);
        h.kind = 8'd0;
        send_frame(h, 0);
        h.kind = 8'd255;
        send_frame(h, 0);
        wait_idle();
        set_limits(8'd9, 8'd3, PAY_LIM_RST, PKT_LIM_RST);
        h = valid_header(0);
        h.kind = 8'd5;
        send_frame(h, 0);
        h.kind = 8'd9;
        send_frame(h, 0);
        wait_idle();
        set_limits(8'd7, 8'd7, PAY_LIM_RST, PKT_LIM_RST);
        h = valid_header(1);
        h.kind = 8'd7;
        send_frame(h, 1);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        set_limits(KIND_LO_RST, KIND_HI_RST, PAY_LIM_RST, PKT_LIM_RST);
        tx_gap_max  = 0;
        rx_hold_req = 300;
        send_frame(valid_header(60), 60);
        tx_gap_max  = 2;
        rx_hold_req = 150;
        send_frame(valid_header(40), 40);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        frame_hdr_t h;
        int         phase_end;
        int         plen;
        flaw_t      flaw;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: set_limits(KIND_LO_RST, KIND_HI_RST, PAY_LIM_RST, PKT_LIM_RST);
                1: set_limits(8'($urandom_range(0, 20)), 8'($urandom_range(0, 40)),
                              16'($urandom_range(0, 40)), 17'($urandom_range(28, 90)));
                2: set_limits(8'd0, 8'd255, 16'hFFFF, 17'd65563);
                3: begin
                    plen = $urandom_range(0, 255);
                    set_limits(8'(plen), 8'(plen), 16'd0, 17'd28);
                end
                4: set_limits(8'($urandom_range(100, 255)), 8'($urandom_range(0, 120)),
                              16'($urandom_range(0, 30)), 17'($urandom_range(40, 120)));
                default: set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 64)), 17'($urandom_range(28, 100)));
            endcase
            phase_end = bytes_sent + 130;
            while (bytes_sent < phase_end) begin
                tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 99) < 75) begin
                    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                       : $urandom_range(0, 20);
                    h    = valid_header(plen);
                    flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE
                                                       : flaw_t'($urandom_range(1, 8));
                    case (flaw)
                        FLAW_MAGIC:   h.magic = h.magic ^ (32'h1 << $urandom_range(0, 31));
                        FLAW_VERSION: begin
                            do h.version = 8'($urandom_range(0, 255));
                            while (h.version == WIRE_VERSION);
                        end
                        FLAW_KIND:    h.kind = illegal_kind();
                        FLAW_FLAGS: begin
                            if ($urandom_range(0, 1) == 0)
                                h.flag_byte = 8'($urandom_range(2, 255));
                            else
                                h.rsv_byte = 8'($urandom_range(1, 255));
                        end
                        FLAW_LENGTH:  h.plen = h.plen ^ (16'h1 << $urandom_range(0, 15));
                        FLAW_ZERO_ID: begin
                            if ($urandom_range(0, 1) == 0) h.session_hash = '0;
                            if ($urandom_range(0, 1) == 0 || h.session_hash != '0)
                                h.sender = '0;
                        end
                        FLAW_LONG: begin
                            if (cfg_pkt_lim < 200) begin
                                plen   = int'(cfg_pkt_lim) - HDR_LEN + $urandom_range(1, 4);
                                h.plen = 16'(plen);
                            end
                        end
                        default: ;
                    endcase
                    push_header(h);
                    push_payload(plen);
                    if (flaw == FLAW_SHORT) begin
                        plen = $urandom_range(1, HDR_LEN - 1);
                        while (pkt_q.size() > plen) void'(pkt_q.pop_back());
                    end
                end else begin
                    push_payload($urandom_range(1, 60));
                end
                send_packet();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_frames();
        test_status_codes();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        $display("Run covered %0d input bytes, giving %0d payload words and %0d summaries.",
                 bytes_sent, payload_seen, summary_seen);
        $display("Status codes seen, one bit per code from 9 down to 0: %b", status_seen);
        if (err_cnt == 0 && due_words.size() == 0) begin
            $display("tb_packet_header_checker OK");
        end else begin
            $display("%0d mismatches, %0d words never arrived", err_cnt, due_words.size());
            $display("tb_packet_header_checker NOT OK");
        end
        $finish;
    end

endmodule
